// File: hw/rtl/brle_pkg.sv
`default_nettype none

package brle_pkg;

	localparam int CAPACITY = 32;
	localparam int SLOTS    = CAPACITY + 1;
	localparam int PTR_W    = $clog2(SLOTS);
	localparam int LOST_W   = 16;

	localparam logic [7:0] DELIM_RESET = 8'd10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef enum logic [2:0] {
		ST_STORED     = 3'd0,
		ST_DROPPED    = 3'd1,
		ST_NO_LINE    = 3'd2,
		ST_LINE_BYTE  = 3'd3,
		ST_EMPTY_LINE = 3'd4
	} status_t;

	typedef struct packed {
		logic       en;
		ptr_t       addr;
		logic [7:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic en;
		ptr_t addr;
	} ram_rd_t;

	function automatic ptr_t ring_next(input ptr_t p);
		return (p == ptr_t'(SLOTS - 1)) ? '0 : p + ptr_t'(1);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/brle_if.sv
`default_nettype none

interface brle_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_in;

	modport source (output valid, output op, output data_in, input ready);
	modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface brle_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  data_out;
	logic        last;
	logic [15:0] lost_bytes;

	modport source (output valid, output status, output data_out, output last,
		output lost_bytes, input ready);
	modport sink   (input valid, input status, input data_out, input last,
		input lost_bytes, output ready);
endinterface

interface brle_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_delimiter;

	modport source (output valid, output line_delimiter, input ready);
	modport sink   (input valid, input line_delimiter, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/brle_ram.sv
`default_nettype none

module brle_ram
	import brle_pkg::*;
(
	input  wire logic       clk,
	input  wire ram_wr_t    wr,
	input  wire ram_rd_t    rd,
	output logic [7:0]      rdata
);

	logic [7:0] mem_q [SLOTS];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem_q[rd.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/byte_ring_line_extractor_core.sv
`default_nettype none

// Byte ring buffer with line extraction. The store has CAPACITY+1 entries in
// one synchronous RAM with one slot kept free, so CAPACITY bytes fit. A write
// item (op 0) gives one result: stored, or dropped when full, which bumps
// lost_bytes (saturating at 65535). Writes sustain one item per cycle as long
// as results are taken. A read item (op 1) scans the RAM from the read
// pointer, one entry per cycle, for line_delimiter. When the delimiter is
// absent a single no-line result comes once every stored byte has been
// checked, and nothing is consumed. On a hit the bytes before the delimiter
// stream out one per cycle while results are taken, with last on the final
// one, or a single empty-line result when the delimiter comes first; the line
// and its delimiter are then consumed. The next item is accepted once the
// block is back in idle and the output is free. The one RAM read port is
// registered, and a result that is not taken stalls both the stream and the
// input. The delimiter register resets to newline; the user must write it
// through cfg only while idle, as the block itself does not enforce this.
// lost_bytes on every result is the drop count after that item.

module byte_ring_line_extractor_core
	import brle_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	brle_req_if.sink    req,
	brle_rsp_if.source  rsp,
	brle_cfg_if.sink    cfg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SINGLE,
		S_EMIT
	} state_t;

	state_t              state_q;
	ptr_t                wr_ptr_q;
	ptr_t                rd_ptr_q;
	logic [LOST_W-1:0]   drop_q;
	logic [7:0]          delim_q;

	// scan / emit bookkeeping
	ptr_t                scan_p_q;    // next address to issue during the scan
	ptr_t                p_s1;        // address whose data sits in rdata
	logic                vld_s1;
	ptr_t                found_q;     // delimiter position
	ptr_t                emit_p_q;    // address of the byte now in rdata
	status_t             single_q;

	// result register
	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [7:0]          rsp_data_q;
	logic                rsp_last_q;

	ram_wr_t             ram_wr;
	ram_rd_t             ram_rd;
	logic [7:0]          rdata;

	logic                out_free;
	logic                req_acc;
	logic                full;
	logic                hit;
	logic                scan_issue;
	logic                last_now;

	brle_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.rd    (ram_rd),
		.rdata (rdata)
	);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign full       = (ring_next(wr_ptr_q) == rd_ptr_q);
	assign hit        = (state_q == S_SCAN) && vld_s1 && (rdata == delim_q);
	assign scan_issue = (state_q == S_SCAN) && !hit && (scan_p_q != wr_ptr_q);
	assign last_now   = (ring_next(emit_p_q) == found_q);

	// Writes happen only from idle and reads only while scanning or emitting,
	// so the two never touch the RAM in the same cycle.
	always_comb begin
		ram_wr.en   = req_acc && (req.op == OP_WRITE) && !full;
		ram_wr.addr = wr_ptr_q;
		ram_wr.data = req.data_in;

		ram_rd.en   = 1'b0;
		ram_rd.addr = scan_p_q;
		unique case (state_q)
			S_SCAN: begin
				if (hit) begin
					// prefetch the first line byte
					ram_rd.en   = (p_s1 != rd_ptr_q);
					ram_rd.addr = rd_ptr_q;
				end else begin
					ram_rd.en   = scan_issue;
					ram_rd.addr = scan_p_q;
				end
			end
			S_EMIT: begin
				ram_rd.en   = out_free && !last_now;
				ram_rd.addr = ring_next(emit_p_q);
			end
			default: begin
				ram_rd.en   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg.valid && cfg.ready) begin
			delim_q <= cfg.line_delimiter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			drop_q       <= '0;
			vld_s1       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			scan_p_q     <= '0;
			p_s1         <= '0;
			found_q      <= '0;
			emit_p_q     <= '0;
			single_q     <= ST_NO_LINE;
			rsp_status_q <= ST_STORED;
			rsp_data_q   <= '0;
			rsp_last_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.op == OP_WRITE) begin
							rsp_valid_q <= 1'b1;
							rsp_data_q  <= '0;
							rsp_last_q  <= 1'b1;
							if (!full) begin
								wr_ptr_q     <= ring_next(wr_ptr_q);
								rsp_status_q <= ST_STORED;
							end else begin
								if (drop_q != '1) begin
									drop_q <= drop_q + LOST_W'(1);
								end
								rsp_status_q <= ST_DROPPED;
							end
						end else begin
							state_q  <= S_SCAN;
							scan_p_q <= rd_ptr_q;
							vld_s1   <= 1'b0;
						end
					end
				end

				S_SCAN: begin
					vld_s1 <= scan_issue;
					p_s1   <= scan_p_q;
					if (scan_issue) begin
						scan_p_q <= ring_next(scan_p_q);
					end
					if (hit) begin
						found_q <= p_s1;
						if (p_s1 == rd_ptr_q) begin
							single_q <= ST_EMPTY_LINE;
							state_q  <= S_SINGLE;
						end else begin
							emit_p_q <= rd_ptr_q;
							state_q  <= S_EMIT;
						end
					end else if (!vld_s1 && (scan_p_q == wr_ptr_q)) begin
						// everything between the pointers checked, no delimiter
						single_q <= ST_NO_LINE;
						state_q  <= S_SINGLE;
					end
				end

				S_SINGLE: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= single_q;
						rsp_data_q   <= '0;
						rsp_last_q   <= 1'b1;
						if (single_q == ST_EMPTY_LINE) begin
							rd_ptr_q <= ring_next(found_q);
						end
						state_q <= S_IDLE;
					end
				end

				S_EMIT: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= ST_LINE_BYTE;
						rsp_data_q   <= rdata;
						rsp_last_q   <= last_now;
						if (last_now) begin
							rd_ptr_q <= ring_next(found_q);
							state_q  <= S_IDLE;
						end else begin
							emit_p_q <= ring_next(emit_p_q);
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.data_out   = rsp_data_q;
	assign rsp.last       = rsp_last_q;
	// the counter moves only when a new result is loaded
	assign rsp.lost_bytes = drop_q;

	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr.en && ram_rd.en))
		else $error("RAM written and read in the same cycle");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q <= ptr_t'(SLOTS - 1)) && (rd_ptr_q <= ptr_t'(SLOTS - 1)))
		else $error("ring pointer out of range");

	a_wr_ptr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wr_ptr_q) |-> $past(state_q) == S_IDLE)
		else $error("write pointer moved outside idle");

	a_emit_before_delim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (emit_p_q != found_q))
		else $error("emitting the delimiter as a line byte");

endmodule

`default_nettype wire
